FILE: sv/dtp_pkg.sv
// Shared types and constants of the dependency-aware task picker.
package dtp_pkg;

  localparam int unsigned TASK_COUNT_DEF = 8;
  localparam int unsigned MAX_TASKS      = 8;   // row stride of the dependency matrix
  localparam int unsigned MOB_W          = 8;
  localparam int unsigned TIME_W         = 32;
  localparam int unsigned TIDX_W         = 3;
  localparam int unsigned DEP_W          = MAX_TASKS * MAX_TASKS;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SELECT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_DECIDE
  } dtp_state_t;

  // One task table entry.
  typedef struct packed {
    logic [MOB_W-1:0]  mob;
    logic [TIME_W-1:0] dl;
    logic [TIME_W-1:0] wt;
  } dtp_entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;     // write the table entry of the accepted item
    logic init;     // latch select operands, clear scan state
    logic rd;       // read the entry at the scan index, advance it
    logic decide;   // form the result and strobe it out
  } dtp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic rd_last;  // scan index is at the last task
  } dtp_sts_t;

endpackage

FILE: sv/dtp_ctrl.sv
// Controller state machine of the task picker.
module dtp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              req_type,
  input  dtp_pkg::dtp_sts_t sts,
  output dtp_pkg::dtp_cmd_t cmd,
  output logic              busy
);

  dtp_pkg::dtp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dtp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dtp_pkg::ST_IDLE: begin
        if (start && req_type == dtp_pkg::REQ_SELECT) state_nxt = dtp_pkg::ST_SCAN;
      end
      dtp_pkg::ST_SCAN: begin
        if (sts.rd_last) state_nxt = dtp_pkg::ST_LAST;
      end
      dtp_pkg::ST_LAST:   state_nxt = dtp_pkg::ST_DECIDE;
      dtp_pkg::ST_DECIDE: state_nxt = dtp_pkg::ST_IDLE;
      default:            state_nxt = dtp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      dtp_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start && req_type == dtp_pkg::REQ_LOAD;
        cmd.init = start && req_type == dtp_pkg::REQ_SELECT;
      end
      dtp_pkg::ST_SCAN:   cmd.rd = 1'b1;
      dtp_pkg::ST_LAST:   ;
      dtp_pkg::ST_DECIDE: cmd.decide = 1'b1;
      default:            ;
    endcase
  end

endmodule

FILE: sv/dtp_datapath.sv
// Task table, dependency register, scan comparator and frequency decision.
module dtp_datapath #(
  parameter int unsigned TASK_COUNT = dtp_pkg::TASK_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dtp_pkg::dtp_cmd_t               cmd,
  output dtp_pkg::dtp_sts_t               sts,
  input  logic                            cfg_we,
  input  logic [dtp_pkg::DEP_W-1:0]       cfg_wdata,
  input  logic [dtp_pkg::TIDX_W-1:0]      task_index,
  input  logic [dtp_pkg::MOB_W-1:0]       mobility_value,
  input  logic [dtp_pkg::TIME_W-1:0]      deadline_value,
  input  logic [dtp_pkg::TIME_W-1:0]      work_time_value,
  input  logic [dtp_pkg::MAX_TASKS-1:0]   alive_mask,
  input  logic [dtp_pkg::TIME_W-1:0]      elapsed_us,
  output logic                            out_valid,
  output logic [dtp_pkg::TIDX_W-1:0]      out_selected_task,
  output logic                            out_high_freq
);

  localparam int unsigned IDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam logic [dtp_pkg::MAX_TASKS-1:0] TASK_MASK =
    dtp_pkg::MAX_TASKS'((16'd1 << TASK_COUNT) - 16'd1);

  dtp_pkg::dtp_entry_t mem [TASK_COUNT];
  dtp_pkg::dtp_entry_t rd_data_r;

  logic [dtp_pkg::DEP_W-1:0]     dep_r;
  logic [dtp_pkg::MAX_TASKS-1:0] alive_r;
  logic [dtp_pkg::TIME_W-1:0]    elapsed_r;
  logic [IDX_W-1:0]              scan_idx_r;
  logic                          rd_vld_r;
  logic                          rd_rdy_r;
  logic [IDX_W-1:0]              cmp_idx_r;
  logic                          found_r;
  logic [IDX_W-1:0]              best_idx_r;
  logic [dtp_pkg::MOB_W-1:0]     best_mob_r;
  logic [dtp_pkg::TIME_W-1:0]    best_dl_r;
  logic [dtp_pkg::TIME_W-1:0]    best_wt_r;
  logic [dtp_pkg::TIME_W-1:0]    fb_dl_r;
  logic [dtp_pkg::TIME_W-1:0]    fb_wt_r;
  logic                          out_valid_r;
  logic [dtp_pkg::TIDX_W-1:0]    out_task_r;
  logic                          out_hf_r;

  logic                          load_ok;
  logic [dtp_pkg::MAX_TASKS-1:0] dep_row;
  logic                          scan_rdy;
  logic                          take;
  logic [dtp_pkg::TIME_W-1:0]    sel_dl;
  logic [dtp_pkg::TIME_W-1:0]    sel_wt;
  logic [dtp_pkg::TIME_W:0]      finish;

  assign load_ok = {1'b0, task_index} < (dtp_pkg::TIDX_W + 1)'(TASK_COUNT);

  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      mem[task_index[IDX_W-1:0]] <= '{mob: mobility_value, dl: deadline_value,
                                      wt: work_time_value};
    end
    if (cmd.rd) begin
      rd_data_r <= mem[scan_idx_r];
    end
  end

  // Ready: alive, and no task in its dependency row is alive.
  assign dep_row  = dep_r[{3'(scan_idx_r), 3'b000} +: dtp_pkg::MAX_TASKS];
  assign scan_rdy = alive_r[scan_idx_r] && ((dep_row & alive_r) == '0);

  assign sts.rd_last = scan_idx_r == IDX_W'(TASK_COUNT - 1);

  // The first ready task is always taken; a later one wins on less mobility, then on strictly earlier deadline.
  assign take = rd_vld_r && rd_rdy_r &&
                (!found_r || rd_data_r.mob < best_mob_r ||
                 (rd_data_r.mob == best_mob_r && rd_data_r.dl < best_dl_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dep_r       <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      scan_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) dep_r <= cfg_wdata;
      rd_vld_r    <= cmd.rd;
      out_valid_r <= cmd.decide;
      if (cmd.init) begin
        scan_idx_r <= '0;
        found_r    <= 1'b0;
      end else begin
        if (cmd.rd) scan_idx_r <= sts.rd_last ? '0 : scan_idx_r + 1'b1;
        if (take) found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      alive_r   <= alive_mask & TASK_MASK;
      elapsed_r <= elapsed_us;
    end
    if (cmd.rd) begin
      rd_rdy_r  <= scan_rdy;
      cmp_idx_r <= scan_idx_r;
    end
    // Task 0's entry is kept for the case that no task is ready.
    if (rd_vld_r && cmp_idx_r == '0) begin
      fb_dl_r <= rd_data_r.dl;
      fb_wt_r <= rd_data_r.wt;
    end
    if (take) begin
      best_idx_r <= cmp_idx_r;
      best_mob_r <= rd_data_r.mob;
      best_dl_r  <= rd_data_r.dl;
      best_wt_r  <= rd_data_r.wt;
    end
  end

  assign sel_dl = found_r ? best_dl_r : fb_dl_r;
  assign sel_wt = found_r ? best_wt_r : fb_wt_r;
  assign finish = {1'b0, sel_wt} + {1'b0, elapsed_r};

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      out_task_r <= found_r ? dtp_pkg::TIDX_W'(best_idx_r) : '0;
      out_hf_r   <= !(finish < {1'b0, sel_dl});
    end
  end

  assign out_valid         = out_valid_r;
  assign out_selected_task = out_task_r;
  assign out_high_freq     = out_hf_r;

endmodule

FILE: sv/dependency_aware_task_picker_top.sv
// Top level of the dependency-aware task picker.
//
//   channel | handshake          | payload
//   --------+--------------------+--------------------------------------------
//   input   | start / busy       | in_req_type, in_task_index, in_mobility_value,
//           |                    | in_deadline_value, in_work_time_value,
//           |                    | in_alive_mask, in_elapsed_us
//   result  | out_valid (1 cyc)  | out_selected_task, out_high_freq
//   config  | cfg_we             | cfg_wdata (dependency matrix)
//
// A load item is written into the task table at its accept edge; busy stays low.
// A select item keeps busy high until its result is formed: the table has one read
// port, so the scan reads one entry per cycle, then state LAST finishes the last
// compare and state DECIDE forms the result. out_valid pulses in the first cycle with
// busy low again. Reset (rst_n low, synchronous) clears the controller and the
// dependency matrix; table entries are undefined until loaded. The receiver cannot
// stall the result.
module dependency_aware_task_picker_top #(
  parameter int unsigned TASK_COUNT = dtp_pkg::TASK_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_req_type,
  input  logic [dtp_pkg::TIDX_W-1:0]    in_task_index,
  input  logic [dtp_pkg::MOB_W-1:0]     in_mobility_value,
  input  logic [dtp_pkg::TIME_W-1:0]    in_deadline_value,
  input  logic [dtp_pkg::TIME_W-1:0]    in_work_time_value,
  input  logic [dtp_pkg::MAX_TASKS-1:0] in_alive_mask,
  input  logic [dtp_pkg::TIME_W-1:0]    in_elapsed_us,
  output logic                          out_valid,
  output logic [dtp_pkg::TIDX_W-1:0]    out_selected_task,
  output logic                          out_high_freq,
  input  logic                          cfg_we,
  input  logic [dtp_pkg::DEP_W-1:0]     cfg_wdata
);

  dtp_pkg::dtp_cmd_t cmd;
  dtp_pkg::dtp_sts_t sts;

  dtp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_req_type),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  dtp_datapath #(
    .TASK_COUNT (TASK_COUNT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .task_index        (in_task_index),
    .mobility_value    (in_mobility_value),
    .deadline_value    (in_deadline_value),
    .work_time_value   (in_work_time_value),
    .alive_mask        (in_alive_mask),
    .elapsed_us        (in_elapsed_us),
    .out_valid         (out_valid),
    .out_selected_task (out_selected_task),
    .out_high_freq     (out_high_freq)
  );

endmodule

FILE: tb/sv/dtp_pick_checker.sv
// Checker for the task picker: tracks the task table and dependencies, predicts picks.
module dtp_pick_checker #(
  parameter int unsigned TASK_COUNT = dtp_pkg::TASK_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          in_req_type,
  input  logic [dtp_pkg::TIDX_W-1:0]    in_task_index,
  input  logic [dtp_pkg::MOB_W-1:0]     in_mobility_value,
  input  logic [dtp_pkg::TIME_W-1:0]    in_deadline_value,
  input  logic [dtp_pkg::TIME_W-1:0]    in_work_time_value,
  input  logic [dtp_pkg::MAX_TASKS-1:0] in_alive_mask,
  input  logic [dtp_pkg::TIME_W-1:0]    in_elapsed_us,
  input  logic                          out_valid,
  input  logic [dtp_pkg::TIDX_W-1:0]    out_selected_task,
  input  logic                          out_high_freq,
  input  logic                          cfg_we,
  input  logic [dtp_pkg::DEP_W-1:0]     cfg_wdata,
  output int                            mismatches,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import dtp_pkg::*;

  localparam int unsigned MOB_START = 1000;  // above any 8-bit mobility

  typedef struct packed {
    logic [TIDX_W-1:0] sel;
    logic              high_freq;
  } pick_t;

  logic [DEP_W-1:0]  dep_q;
  logic [MOB_W-1:0]  mob_tbl [MAX_TASKS];
  logic [TIME_W-1:0] dl_tbl  [MAX_TASKS];
  logic [TIME_W-1:0] wt_tbl  [MAX_TASKS];
  pick_t             pick_q[$];
  pick_t             want;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    dep_q       = '0;
    for (int k = 0; k < MAX_TASKS; k++) begin
      mob_tbl[k] = '0;
      dl_tbl[k]  = '0;
      wt_tbl[k]  = '0;
    end
  end

  function automatic pick_t predict_pick(input logic [MAX_TASKS-1:0] alive,
                                         input logic [TIME_W-1:0] elapsed);
    int unsigned   best;
    int unsigned   best_mob;
    logic [TIME_W-1:0] best_dl;
    logic [TIME_W:0]   finish;
    logic          ready;
    pick_t         p;
    best     = 0;
    best_mob = MOB_START;
    best_dl  = '0;
    for (int i = 0; i < TASK_COUNT; i++) begin
      ready = alive[i];
      for (int j = 0; j < TASK_COUNT; j++)
        if (dep_q[i*MAX_TASKS+j] && alive[j]) ready = 1'b0;
      if (!ready) continue;
      if (mob_tbl[i] < best_mob) begin
        best     = i;
        best_mob = mob_tbl[i];
        best_dl  = dl_tbl[i];
      end else if (mob_tbl[i] == best_mob && dl_tbl[i] < best_dl) begin
        best    = i;
        best_dl = dl_tbl[i];
      end
    end
    // 33-bit sum, never wraps
    finish      = {1'b0, wt_tbl[best]} + {1'b0, elapsed};
    p.sel       = best[TIDX_W-1:0];
    p.high_freq = (finish < {1'b0, dl_tbl[best]}) ? 1'b0 : 1'b1;
    return p;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      dep_q = '0;
      pick_q.delete();
    end else begin
      // result first: it always belongs to an earlier item
      if (out_valid) begin
        if (pick_q.size() == 0) begin
          $error("result with no item pending: selected_task %0d, high_freq %0d",
                 out_selected_task, out_high_freq);
          mismatches++;
        end else begin
          want = pick_q.pop_front();
          if (out_selected_task !== want.sel) begin
            $error("selected_task: expected %0d, got %0d", want.sel, out_selected_task);
            mismatches++;
          end
          if (out_high_freq !== want.high_freq) begin
            $error("high_freq: expected %0d, got %0d", want.high_freq, out_high_freq);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        if (in_req_type == REQ_LOAD) begin
          if (in_task_index < TASK_COUNT) begin
            mob_tbl[in_task_index] = in_mobility_value;
            dl_tbl[in_task_index]  = in_deadline_value;
            wt_tbl[in_task_index]  = in_work_time_value;
          end
        end else begin
          pick_q.push_back(predict_pick(in_alive_mask, in_elapsed_us));
        end
      end
      if (cfg_we) dep_q = cfg_wdata;
    end
    outstanding <= pick_q.size();
  end

endmodule

FILE: tb/sv/tb_dependency_aware_task_picker_top.sv
// Testbench top for the task picker: stimulus, config phases and verdict.
module tb_dependency_aware_task_picker_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dtp_pkg::*;

  localparam int unsigned TASK_COUNT = TASK_COUNT_DEF;
  localparam int unsigned SETTLE     = TASK_COUNT + 4;
  localparam int          CYCLE_CAP  = 200000;
  localparam int          PHASES     = 6;
  localparam int          PHASE_ITEMS = 88;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_req_type = REQ_LOAD;
  logic [TIDX_W-1:0]    in_task_index = '0;
  logic [MOB_W-1:0]     in_mobility_value = '0;
  logic [TIME_W-1:0]    in_deadline_value = '0;
  logic [TIME_W-1:0]    in_work_time_value = '0;
  logic [MAX_TASKS-1:0] in_alive_mask = '0;
  logic [TIME_W-1:0]    in_elapsed_us = '0;
  logic                 out_valid;
  logic [TIDX_W-1:0]    out_selected_task;
  logic                 out_high_freq;
  logic                 cfg_we = 1'b0;
  logic [DEP_W-1:0]     cfg_wdata = '0;

  int                   mismatches;
  int                   outstanding;
  int                   cycles = 0;
  bit                   idle_en = 1'b1;
  logic [DEP_W-1:0]     dep_set [PHASES];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  dependency_aware_task_picker_top #(.TASK_COUNT(TASK_COUNT)) DUT (
    .clk, .rst_n, .start, .busy,
    .in_req_type, .in_task_index, .in_mobility_value, .in_deadline_value,
    .in_work_time_value, .in_alive_mask, .in_elapsed_us,
    .out_valid, .out_selected_task, .out_high_freq,
    .cfg_we, .cfg_wdata
  );

  dtp_pick_checker #(.TASK_COUNT(TASK_COUNT)) u_checker (
    .clk, .rst_n, .start, .busy,
    .in_req_type, .in_task_index, .in_mobility_value, .in_deadline_value,
    .in_work_time_value, .in_alive_mask, .in_elapsed_us,
    .out_valid, .out_selected_task, .out_high_freq,
    .cfg_we, .cfg_wdata,
    .mismatches, .outstanding
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("dependency_aware_task_picker_top: mismatch");
      $finish;
    end
  end

  // Present one item and hold it until accepted; maybe go quiet afterwards.
  task automatic issue(input logic req, input logic [TIDX_W-1:0] idx,
                       input logic [MOB_W-1:0] mob, input logic [TIME_W-1:0] dl,
                       input logic [TIME_W-1:0] wt, input logic [MAX_TASKS-1:0] alive,
                       input logic [TIME_W-1:0] elapsed);
    start              <= 1'b1;
    in_req_type        <= req;
    in_task_index      <= idx;
    in_mobility_value  <= mob;
    in_deadline_value  <= dl;
    in_work_time_value <= wt;
    in_alive_mask      <= alive;
    in_elapsed_us      <= elapsed;
    @(posedge clk);
    while (busy) @(posedge clk);
    // each cycle the sender could go it stays quiet about a third of the time
    while (idle_en && $urandom_range(99) < 34) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (busy || outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_dep(input logic [DEP_W-1:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [TIME_W-1:0] pick_time(input int narrow);
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    if (r < 60) return TIME_W'($urandom_range(0, narrow));
    return $urandom();
  endfunction

  task automatic random_item();
    logic [MOB_W-1:0]     mob;
    logic [MAX_TASKS-1:0] alive;
    int                   r;
    r = $urandom_range(99);
    if (r < 40) mob = MOB_W'($urandom_range(0, 3));   // mobility ties
    else if (r < 50) mob = (r < 45) ? '0 : '1;
    else mob = MOB_W'($urandom());
    r = $urandom_range(99);
    if (r < 8) alive = '0;
    else if (r < 18) alive = '1;
    else alive = MAX_TASKS'($urandom());
    if ($urandom_range(99) < 35)
      issue(REQ_LOAD, TIDX_W'($urandom()), mob, pick_time(4000), pick_time(2000),
            alive, $urandom());
    else
      issue(REQ_SELECT, TIDX_W'($urandom()), mob, $urandom(), $urandom(),
            alive, pick_time(2000));
  endtask

  initial begin
    dep_set[0] = '1;                              // every task waits on itself
    dep_set[1] = {$urandom(), $urandom()};
    dep_set[2] = '0;
    dep_set[3] = {$urandom(), $urandom()} & {$urandom(), $urandom()};
    dep_set[4] = '0;
    dep_set[5] = '0;
    // acyclic chains: lower triangle for one phase, upper for another
    for (int i = 0; i < MAX_TASKS; i++)
      for (int j = 0; j < MAX_TASKS; j++) begin
        if (j < i && $urandom_range(99) < 30) dep_set[2][i*MAX_TASKS+j] = 1'b1;
        if (j > i && $urandom_range(99) < 20) dep_set[4][i*MAX_TASKS+j] = 1'b1;
      end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    write_dep('0);

    // every entry loaded before any select reads the table
    issue(REQ_LOAD, 3'd0, 8'd5,   32'd1000,       32'd100,        '0, '0);
    issue(REQ_LOAD, 3'd1, 8'd0,   32'hFFFF_FFFF,  32'hFFFF_FFFF,  '1, '1);
    issue(REQ_LOAD, 3'd2, 8'd255, 32'd0,          32'd0,          '0, '0);
    issue(REQ_LOAD, 3'd3, 8'd7,   32'd500,        32'd200,        '0, '0);
    issue(REQ_LOAD, 3'd4, 8'd7,   32'd400,        32'd100,        '0, '0);
    issue(REQ_LOAD, 3'd5, 8'd7,   32'd400,        32'd50,         '0, '0);
    issue(REQ_LOAD, 3'd6, 8'd255, 32'd0,          32'd0,          '0, '0);
    issue(REQ_LOAD, 3'd7, 8'd128, 32'h8000_0000,  32'h7FFF_FFFF,  '0, '0);
    // nothing alive falls back to task 0; all alive picks the lowest mobility
    issue(REQ_SELECT, '0, '0, '0, '0, 8'h00, 32'd0);
    issue(REQ_SELECT, '0, '0, '0, '0, 8'hFF, 32'd0);
    // equal mobility: earlier deadline beats lower index, exact tie keeps lower
    issue(REQ_SELECT, '1, '1, '1, '1, 8'h38, 32'd0);
    issue(REQ_SELECT, '0, '0, '0, '0, 8'h38, 32'd300);   // finish equals deadline
    issue(REQ_SELECT, '0, '0, '0, '0, 8'h38, 32'd299);
    issue(REQ_SELECT, '0, '0, '0, '0, 8'h44, 32'd0);
    issue(REQ_SELECT, '0, '0, '0, '0, 8'h80, 32'hFFFF_FFFF);
    issue(REQ_SELECT, '0, '0, '0, '0, 8'h80, 32'd0);
    issue(REQ_SELECT, '0, '0, '0, '0, 8'h02, 32'hFFFF_FFFF);  // sum carries past 32 bits
    issue(REQ_SELECT, '0, '0, '0, '0, 8'h01, 32'd899);

    for (int ph = 0; ph < PHASES; ph++) begin
      write_dep(dep_set[ph]);
      idle_en = (ph != 2);
      repeat (PHASE_ITEMS) random_item();
    end

    drain();
    if (mismatches == 0 && outstanding == 0)
      $display("dependency_aware_task_picker_top: match");
    else
      $display("dependency_aware_task_picker_top: mismatch");
    $finish;
  end

endmodule
